/* rtl/core/pbrd_pkg.sv */
// ----------------------------------------------------------------------------
// Pulse beat rate detector package
// Shared widths, constants, register indexes, sequencer states and the
// request and response bundles of the shared divider.
// ----------------------------------------------------------------------------
package pbrd_pkg;

	// Depth of the interval history ring.
	localparam int HIST_DEPTH = 4;

	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 12;
	localparam int HYST_W     = 11;
	localparam int IVL_W      = 16;
	localparam int BPM_W      = 16;
	localparam int QUAL_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// The interval sum needs room for HIST_DEPTH full-scale intervals.
	localparam int SUM_W      = IVL_W + $clog2(HIST_DEPTH);
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

	localparam logic [BPM_W-1:0]  BPM_NUMERATOR = 16'd60000;
	localparam logic [BPM_W-1:0]  BPM_MIN       = 16'd40;
	localparam logic [BPM_W-1:0]  BPM_MAX       = 16'd180;
	localparam logic [QUAL_W-1:0] QUALITY_GOOD  = 7'd80;
	localparam logic [QUAL_W-1:0] QUALITY_POOR  = 7'd20;
	localparam logic [CNT_W-1:0]  MIN_INTERVALS = CNT_W'(2);

	localparam logic [THR_W-1:0]  THR_RESET  = 12'd2048;
	localparam logic [HYST_W-1:0] HYST_RESET = 11'd100;
	localparam logic [IVL_W-1:0]  MIN_RESET  = 16'd333;
	localparam logic [IVL_W-1:0]  MAX_RESET  = 16'd1500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEAT_THRESHOLD,
		REG_HYSTERESIS,
		REG_MIN_INTERVAL,
		REG_MAX_INTERVAL
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV_AVG,
		ST_DIV_BPM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [IVL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/pbrd_sample_if.sv */
// ----------------------------------------------------------------------------
// Pulse sample channel
// Valid/ready channel that carries one sensor sample and its timestamp.
// ----------------------------------------------------------------------------
interface pbrd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [pbrd_pkg::SAMPLE_W-1:0] sample;
	logic [pbrd_pkg::TIME_W-1:0]   time_ms;

	modport source (output valid, output sample, output time_ms, input ready);
	modport sink (input valid, input sample, input time_ms, output ready);
endinterface

/* rtl/core/pbrd_result_if.sv */
// ----------------------------------------------------------------------------
// Beat result channel
// Valid/ready channel that carries the beat flag, rate and status of a sample.
// ----------------------------------------------------------------------------
interface pbrd_result_if;
	logic                        valid;
	logic                        ready;
	logic                        beat;
	logic [pbrd_pkg::BPM_W-1:0]  bpm;
	logic                        bpm_valid;
	logic [pbrd_pkg::QUAL_W-1:0] quality;
	logic                        level_high;

	modport source (output valid, output beat, output bpm, output bpm_valid,
		output quality, output level_high, input ready);
	modport sink (input valid, input beat, input bpm, input bpm_valid,
		input quality, input level_high, output ready);
endinterface

/* rtl/core/pbrd_div.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; a done pulse follows the last step.
// ----------------------------------------------------------------------------
module pbrd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pbrd_pkg::div_req_t req,
	output pbrd_pkg::div_rsp_t rsp
);

	logic [pbrd_pkg::IVL_W-1:0]     rem_q;
	logic [pbrd_pkg::SUM_W-1:0]     quo_q;
	logic [pbrd_pkg::IVL_W-1:0]     div_q;
	logic [pbrd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [pbrd_pkg::IVL_W:0]       trial;
	logic [pbrd_pkg::IVL_W:0]       diff;
	logic                           fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[pbrd_pkg::SUM_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pbrd_pkg::DIV_CNT_W'(pbrd_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - pbrd_pkg::DIV_CNT_W'(1);
				if (cnt_q == pbrd_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pbrd_pkg::IVL_W-1:0] : trial[pbrd_pkg::IVL_W-1:0];
			quo_q <= {quo_q[pbrd_pkg::SUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/core/pulse_beat_rate_detector_unit.sv */
// ----------------------------------------------------------------------------
// Pulse beat rate detector
// Hysteresis beat comparator, interval history ring and beats-per-minute
// calculation through one shared iterative divider.
// ----------------------------------------------------------------------------
// A sample that does not update the rate passes through the finish state into the output
// register, and the block takes the next sample once that result is presented. A rate
// update first sums the stored intervals; the shared divider then retires one quotient bit
// per cycle and runs twice (average, then 60000 / average), or once for a zero average.
// One sample is in work at a time. Reset clears the comparator, beat time, counters and rate
// and loads the register defaults; the interval ring is not reset.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	pbrd_sample_if.sink                       samples,
	pbrd_result_if.source                     results,
	input  logic                              cfg_wr_en,
	input  logic [pbrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbrd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [pbrd_pkg::THR_W-1:0]  thr_q;
	logic [pbrd_pkg::HYST_W-1:0] hyst_q;
	logic [pbrd_pkg::IVL_W-1:0]  min_q;
	logic [pbrd_pkg::IVL_W-1:0]  max_q;

	// Detector state.
	pbrd_pkg::state_t            state_q;
	pbrd_pkg::state_t            state_d;
	logic                        is_high_q;
	logic [pbrd_pkg::TIME_W-1:0] last_beat_q;
	logic [pbrd_pkg::IVL_W-1:0]  ring_q [pbrd_pkg::HIST_DEPTH];
	logic [pbrd_pkg::CNT_W-1:0]  total_q;
	logic [pbrd_pkg::SLOT_W-1:0] slot_q;
	logic [pbrd_pkg::BPM_W-1:0]  rate_q;
	logic                        beat_q;

	// Summation over the ring.
	logic [pbrd_pkg::SLOT_W-1:0] sum_idx_q;
	logic [pbrd_pkg::SUM_W-1:0]  acc_q;

	// Output register.
	logic                        out_valid_q;
	logic                        out_beat_q;
	logic [pbrd_pkg::BPM_W-1:0]  out_bpm_q;
	logic                        out_bpm_valid_q;
	logic [pbrd_pkg::QUAL_W-1:0] out_quality_q;
	logic                        out_level_q;

	pbrd_pkg::div_req_t          div_req;
	pbrd_pkg::div_rsp_t          div_rsp;

	logic                        accepted;
	logic [pbrd_pkg::THR_W:0]    rise_level;
	logic [pbrd_pkg::THR_W:0]    fall_sum;
	logic                        rise;
	logic                        new_high;
	logic [pbrd_pkg::TIME_W-1:0] gap;
	logic                        gap_ok;
	logic                        take_ivl;
	logic [pbrd_pkg::CNT_W-1:0]  total_inc;
	logic                        need_rate;
	logic [pbrd_pkg::SUM_W-1:0]  sum_next;
	logic                        sum_last;
	logic [pbrd_pkg::IVL_W-1:0]  avg;
	logic                        avg_zero;
	logic                        out_load;

	pbrd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Comparator and interval check, evaluated on the incoming item.
	// The rising level is threshold plus hysteresis; it is one bit wider
	// than a sample, so a level above full scale is simply never reached.
	// The falling test compares sample plus hysteresis against threshold,
	// which handles a hysteresis larger than the threshold without a
	// negative level: the comparator then never falls.
	// ------------------------------------------------------------------
	always_comb begin
		accepted   = samples.valid && samples.ready;
		rise_level = {1'b0, thr_q} + {2'b0, hyst_q};
		fall_sum   = {1'b0, samples.sample} + {2'b0, hyst_q};
		rise       = !is_high_q && ({1'b0, samples.sample} > rise_level);
		// A sample that just rose can never also satisfy the falling test.
		new_high   = rise || (is_high_q && !(fall_sum < {1'b0, thr_q}));

		// The interval wraps modulo 2^32 along with the millisecond tick.
		gap        = samples.time_ms - last_beat_q;
		gap_ok     = (last_beat_q != '0)
			&& (gap >= {{(pbrd_pkg::TIME_W - pbrd_pkg::IVL_W){1'b0}}, min_q})
			&& (gap <= {{(pbrd_pkg::TIME_W - pbrd_pkg::IVL_W){1'b0}}, max_q});
		take_ivl   = rise && gap_ok;

		// The interval count saturates at the ring depth.
		total_inc  = (total_q == pbrd_pkg::CNT_W'(pbrd_pkg::HIST_DEPTH))
			? total_q : total_q + pbrd_pkg::CNT_W'(1);
		need_rate  = take_ivl && (total_inc >= pbrd_pkg::MIN_INTERVALS);
	end

	// Ring summation: one entry per cycle, from slot zero up to the count.
	// Only written slots are summed because the ring fills from slot zero.
	always_comb begin
		sum_next = acc_q + pbrd_pkg::SUM_W'(ring_q[sum_idx_q]);
		sum_last = (pbrd_pkg::CNT_W'(sum_idx_q) == total_q - pbrd_pkg::CNT_W'(1));
		avg      = div_rsp.quotient[pbrd_pkg::IVL_W-1:0];
		avg_zero = (avg == '0);
		out_load = (state_q == pbrd_pkg::ST_FINISH) && (!out_valid_q || results.ready);
	end

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbrd_pkg::ST_IDLE: begin
				if (accepted) begin
					state_d = need_rate ? pbrd_pkg::ST_SUM : pbrd_pkg::ST_FINISH;
				end
			end
			pbrd_pkg::ST_SUM: begin
				if (sum_last) begin
					state_d = pbrd_pkg::ST_DIV_AVG;
				end
			end
			pbrd_pkg::ST_DIV_AVG: begin
				if (div_rsp.done) begin
					// An all-zero average skips the second division.
					state_d = avg_zero ? pbrd_pkg::ST_FINISH : pbrd_pkg::ST_DIV_BPM;
				end
			end
			pbrd_pkg::ST_DIV_BPM: begin
				if (div_rsp.done) begin
					state_d = pbrd_pkg::ST_FINISH;
				end
			end
			pbrd_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = pbrd_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs. The divider first takes the interval sum over
	// the count, then, for a nonzero average, 60000 over the average it returned.
	// ------------------------------------------------------------------
	always_comb begin
		samples.ready    = (state_q == pbrd_pkg::ST_IDLE);
		div_req.start    = ((state_q == pbrd_pkg::ST_SUM) && sum_last)
			|| ((state_q == pbrd_pkg::ST_DIV_AVG) && div_rsp.done && !avg_zero);
		if (state_q == pbrd_pkg::ST_SUM) begin
			div_req.dividend = sum_next;
			div_req.divisor  = pbrd_pkg::IVL_W'(total_q);
		end else begin
			div_req.dividend = pbrd_pkg::SUM_W'(pbrd_pkg::BPM_NUMERATOR);
			div_req.divisor  = avg;
		end
	end

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbrd_pkg::ST_IDLE;
			thr_q       <= pbrd_pkg::THR_RESET;
			hyst_q      <= pbrd_pkg::HYST_RESET;
			min_q       <= pbrd_pkg::MIN_RESET;
			max_q       <= pbrd_pkg::MAX_RESET;
			is_high_q   <= 1'b0;
			last_beat_q <= '0;
			total_q     <= '0;
			slot_q      <= '0;
			rate_q      <= '0;
			beat_q      <= 1'b0;
			sum_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr_en) begin
				unique case (cfg_index)
					pbrd_pkg::REG_BEAT_THRESHOLD: thr_q  <= cfg_data[pbrd_pkg::THR_W-1:0];
					pbrd_pkg::REG_HYSTERESIS:     hyst_q <= cfg_data[pbrd_pkg::HYST_W-1:0];
					pbrd_pkg::REG_MIN_INTERVAL:   min_q  <= cfg_data;
					pbrd_pkg::REG_MAX_INTERVAL:   max_q  <= cfg_data;
				endcase
			end

			if (accepted) begin
				is_high_q <= new_high;
				beat_q    <= need_rate;
				sum_idx_q <= '0;
				// A rejected interval still moves the beat time.
				if (rise) begin
					last_beat_q <= samples.time_ms;
				end
				if (take_ivl) begin
					total_q <= total_inc;
					slot_q  <= (slot_q == pbrd_pkg::SLOT_W'(pbrd_pkg::HIST_DEPTH - 1))
						? '0 : slot_q + pbrd_pkg::SLOT_W'(1);
				end
			end

			if (state_q == pbrd_pkg::ST_SUM) begin
				sum_idx_q <= sum_idx_q + pbrd_pkg::SLOT_W'(1);
			end

			if ((state_q == pbrd_pkg::ST_DIV_AVG) && div_rsp.done && avg_zero) begin
				rate_q <= pbrd_pkg::BPM_NUMERATOR;
			end else if ((state_q == pbrd_pkg::ST_DIV_BPM) && div_rsp.done) begin
				rate_q <= div_rsp.quotient[pbrd_pkg::BPM_W-1:0];
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Interval ring, accumulator and output payload: no reset needed.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accepted && take_ivl) begin
			ring_q[slot_q] <= gap[pbrd_pkg::IVL_W-1:0];
		end
		if (accepted) begin
			acc_q <= '0;
		end else if (state_q == pbrd_pkg::ST_SUM) begin
			acc_q <= sum_next;
		end
		if (out_load) begin
			out_beat_q      <= beat_q;
			out_bpm_q       <= rate_q;
			out_bpm_valid_q <= (rate_q >= pbrd_pkg::BPM_MIN) && (rate_q <= pbrd_pkg::BPM_MAX)
				&& (total_q >= pbrd_pkg::MIN_INTERVALS);
			out_quality_q   <= (total_q >= pbrd_pkg::MIN_INTERVALS)
				? pbrd_pkg::QUALITY_GOOD : pbrd_pkg::QUALITY_POOR;
			out_level_q     <= is_high_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.beat       = out_beat_q;
	assign results.bpm        = out_bpm_q;
	assign results.bpm_valid  = out_bpm_valid_q;
	assign results.quality    = out_quality_q;
	assign results.level_high = out_level_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= pbrd_pkg::CNT_W'(pbrd_pkg::HIST_DEPTH))
		else $error("interval count exceeds ring depth");

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == pbrd_pkg::ST_DIV_AVG || state_q == pbrd_pkg::ST_DIV_BPM))
		else $error("divider finished outside a divide state");

	a_finish_presents_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("finished item not presented on the result channel");

	a_beat_needs_intervals: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.beat) |-> (total_q >= pbrd_pkg::MIN_INTERVALS))
		else $error("beat reported with fewer than two intervals");

	a_update_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accepted && need_rate) |=> (state_q == pbrd_pkg::ST_SUM))
		else $error("rate update did not start the ring sum");

endmodule

/* tb/sv/tb_pulse_beat_rate_detector_unit.sv */
// ----------------------------------------------------------------------------
// Pulse beat rate detector testbench
// Drives sensor samples into the detector and checks every beat result
// against a cycle-free model of the comparator, interval ring and rate math.
// It covers directed edge cases, extreme register settings, random pulse
// trains under four idling mixes, and a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_beat_rate_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// One beat result as the result channel presents it.
	typedef struct packed {
		logic                        beat;
		logic [pbrd_pkg::BPM_W-1:0]  bpm;
		logic                        bpm_valid;
		logic [pbrd_pkg::QUAL_W-1:0] quality;
		logic                        level_high;
	} beat_report_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	pbrd_pkg::cfg_reg_t              cfg_index;
	logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data;

	pbrd_sample_if sample_ch();
	pbrd_result_if result_ch();

	pulse_beat_rate_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies that the beat model works from. They change only
	// together with a write on the configuration port.
	logic [pbrd_pkg::THR_W-1:0]  thr_cfg;
	logic [pbrd_pkg::HYST_W-1:0] hyst_cfg;
	logic [pbrd_pkg::IVL_W-1:0]  min_ivl_cfg;
	logic [pbrd_pkg::IVL_W-1:0]  max_ivl_cfg;

	// Beat model state.
	logic                        level_is_high;
	logic [pbrd_pkg::TIME_W-1:0] prev_beat_ms;
	logic [pbrd_pkg::IVL_W-1:0]  ivl_history [pbrd_pkg::HIST_DEPTH];
	logic [pbrd_pkg::CNT_W-1:0]  ivl_stored;
	logic [pbrd_pkg::SLOT_W-1:0] ivl_next_slot;
	logic [pbrd_pkg::BPM_W-1:0]  model_bpm;

	// Reports that the block still owes, oldest first.
	beat_report_t pending_reports[$];

	int mismatch_count = 0;
	int items_sent     = 0;

	// Idling mix, in percent per cycle, for the sender and the receiver.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// A test asks for a result-side hold-off by setting its length and
	// toggling the request bit; the receiver process owns the countdown.
	int   hold_off_len  = 0;
	logic hold_off_req  = 1'b0;
	logic hold_off_seen = 1'b0;
	int   hold_off_left = 0;

	// Timestamp of the next beat in the pulse trains; starts anywhere so that
	// every time bit and the 32-bit wrap get exercised.
	logic [pbrd_pkg::TIME_W-1:0] train_time;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Safety net: a hang anywhere ends the run as a failure.
	initial begin
		#20_000_000;
		$display("tb_pulse_beat_rate_detector_unit: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Beat model
	// ------------------------------------------------------------------------

	task automatic clear_model();
		thr_cfg       = pbrd_pkg::THR_RESET;
		hyst_cfg      = pbrd_pkg::HYST_RESET;
		min_ivl_cfg   = pbrd_pkg::MIN_RESET;
		max_ivl_cfg   = pbrd_pkg::MAX_RESET;
		level_is_high = 1'b0;
		prev_beat_ms  = '0;
		ivl_stored    = '0;
		ivl_next_slot = '0;
		model_bpm     = '0;
	endtask

	// Applies one sample to the model and returns the report it should cause.
	function automatic beat_report_t predict_beat_report(
			logic [pbrd_pkg::SAMPLE_W-1:0] level, logic [pbrd_pkg::TIME_W-1:0] stamp);
		beat_report_t rep;
		logic [pbrd_pkg::TIME_W-1:0] gap;
		int unsigned ivl_sum;
		int unsigned ivl_avg;
		int i;
		rep.beat = 1'b0;
		// The rising edge needs strictly more than threshold plus hysteresis.
		// The sum is taken in 32 bits, so a rising level above full scale is
		// simply never reached.
		if (!level_is_high && int'(level) > int'(thr_cfg) + int'(hyst_cfg)) begin
			level_is_high = 1'b1;
			// A previous beat stamped at zero counts as no previous beat.
			if (prev_beat_ms != '0) begin
				gap = stamp - prev_beat_ms;
				if (gap >= pbrd_pkg::TIME_W'(min_ivl_cfg)
						&& gap <= pbrd_pkg::TIME_W'(max_ivl_cfg)) begin
					ivl_history[ivl_next_slot] = gap[pbrd_pkg::IVL_W-1:0];
					ivl_next_slot = ivl_next_slot + pbrd_pkg::SLOT_W'(1);
					if (ivl_stored < pbrd_pkg::CNT_W'(pbrd_pkg::HIST_DEPTH))
						ivl_stored = ivl_stored + pbrd_pkg::CNT_W'(1);
					if (ivl_stored >= pbrd_pkg::MIN_INTERVALS) begin
						// Only the slots written so far are summed: the ring
						// fills from slot zero and the count saturates.
						ivl_sum = 0;
						for (i = 0; i < int'(ivl_stored); i++)
							ivl_sum += ivl_history[i];
						ivl_avg = ivl_sum / ivl_stored;
						if (ivl_avg == 0)
							model_bpm = pbrd_pkg::BPM_NUMERATOR;
						else
							model_bpm = pbrd_pkg::BPM_W'(
								int'(pbrd_pkg::BPM_NUMERATOR) / ivl_avg);
						rep.beat = 1'b1;
					end
				end
			end
			// The beat time moves on even when the interval is rejected.
			prev_beat_ms = stamp;
		end
		// A hysteresis above the threshold makes the falling level negative,
		// so the comparator then never falls.
		if (level_is_high && int'(level) + int'(hyst_cfg) < int'(thr_cfg))
			level_is_high = 1'b0;
		rep.bpm        = model_bpm;
		rep.bpm_valid  = model_bpm >= pbrd_pkg::BPM_MIN && model_bpm <= pbrd_pkg::BPM_MAX &&
			ivl_stored >= pbrd_pkg::MIN_INTERVALS;
		rep.quality    = (ivl_stored >= pbrd_pkg::MIN_INTERVALS)
			? pbrd_pkg::QUALITY_GOOD : pbrd_pkg::QUALITY_POOR;
		rep.level_high = level_is_high;
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Result side: stalls, hold-off and checking
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		beat_report_t got;
		beat_report_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.beat, result_ch.bpm, result_ch.bpm_valid,
					result_ch.quality, result_ch.level_high};
				if (pending_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected beat=%0d bpm=%0d ok=%0d q=%0d lvl=%0d",
							$realtime, got.beat, got.bpm, got.bpm_valid, got.quality,
							got.level_high);
				end else begin
					want = pending_reports.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: expected beat=%0d bpm=%0d ok=%0d q=%0d lvl=%0d",
								$realtime, want.beat, want.bpm, want.bpm_valid,
								want.quality, want.level_high);
							$display("%0t: actual   beat=%0d bpm=%0d ok=%0d q=%0d lvl=%0d",
								$realtime, got.beat, got.bpm, got.bpm_valid,
								got.quality, got.level_high);
						end
					end
				end
			end
			// A fresh hold-off request starts a long stretch with ready low.
			if (hold_off_req != hold_off_seen) begin
				hold_off_seen = hold_off_req;
				hold_off_left = hold_off_len;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------------

	// Offers one sample and returns at the edge where it is taken. Valid is
	// left high, so back-to-back items keep it asserted without a dip.
	task automatic send_sample(logic [pbrd_pkg::SAMPLE_W-1:0] level,
			logic [pbrd_pkg::TIME_W-1:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.sample  <= level;
		sample_ch.time_ms <= stamp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		pending_reports.push_back(predict_beat_report(level, stamp));
		items_sent++;
	endtask

	// Stops offering items and waits until every owed result has come, plus a
	// few cycles so that the block is surely back at rest.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles. The unused upper data
	// bits of the narrow registers carry junk that the block must drop.
	task automatic load_config(logic [pbrd_pkg::THR_W-1:0] thr,
			logic [pbrd_pkg::HYST_W-1:0] hyst,
			logic [pbrd_pkg::IVL_W-1:0] ivl_lo, logic [pbrd_pkg::IVL_W-1:0] ivl_hi);
		cfg_wr_en <= 1'b1;
		cfg_index <= pbrd_pkg::REG_BEAT_THRESHOLD;
		cfg_data  <= {4'($urandom), thr};
		@(posedge clk);
		cfg_index <= pbrd_pkg::REG_HYSTERESIS;
		cfg_data  <= {5'($urandom), hyst};
		@(posedge clk);
		cfg_index <= pbrd_pkg::REG_MIN_INTERVAL;
		cfg_data  <= ivl_lo;
		@(posedge clk);
		cfg_index <= pbrd_pkg::REG_MAX_INTERVAL;
		cfg_data  <= ivl_hi;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		thr_cfg     = thr;
		hyst_cfg    = hyst;
		min_ivl_cfg = ivl_lo;
		max_ivl_cfg = ivl_hi;
		@(posedge clk);
	endtask

	// A level that raises the comparator, or full scale when none can.
	function automatic logic [pbrd_pkg::SAMPLE_W-1:0] rising_level();
		if (int'(thr_cfg) + int'(hyst_cfg) >= 4095)
			return '1;
		return pbrd_pkg::SAMPLE_W'($urandom_range(4095, int'(thr_cfg) + int'(hyst_cfg) + 1));
	endfunction

	// A level that drops the comparator, or zero when none can.
	function automatic logic [pbrd_pkg::SAMPLE_W-1:0] falling_level();
		if (thr_cfg <= hyst_cfg)
			return '0;
		return pbrd_pkg::SAMPLE_W'($urandom_range(int'(thr_cfg) - int'(hyst_cfg) - 1, 0));
	endfunction

	// A train of well-formed pulses: a rising sample at each beat time, then a
	// short tail that ends below the falling level, or at zero when none exists. Most
	// intervals lie inside the accepted window; some fall outside it on either side.
	task automatic run_pulse_train(int beats);
		int ivl_lo;
		int ivl_hi;
		int gap;
		int tail;
		int b;
		int k;
		ivl_lo = (min_ivl_cfg <= max_ivl_cfg) ? int'(min_ivl_cfg) : int'(max_ivl_cfg);
		ivl_hi = (min_ivl_cfg <= max_ivl_cfg) ? int'(max_ivl_cfg) : int'(min_ivl_cfg);
		for (b = 0; b < beats; b++) begin
			if ($urandom_range(99) < 85)
				gap = $urandom_range(ivl_hi, ivl_lo);
			else
				gap = $urandom_range(ivl_hi + ivl_hi / 2 + 2, 1);
			send_sample(rising_level(), train_time);
			tail = $urandom_range(3, 1);
			for (k = 1; k <= tail; k++) begin
				if (k == tail || $urandom_range(1) == 0)
					send_sample(falling_level(), train_time + pbrd_pkg::TIME_W'(k));
				else
					send_sample(pbrd_pkg::SAMPLE_W'($urandom),
						train_time + pbrd_pkg::TIME_W'(k));
			end
			train_time += pbrd_pkg::TIME_W'(gap);
		end
	endtask

	// Mostly pulse trains with random content; the rest is noise with random
	// levels and timestamps, which breaks the interval chain.
	task automatic run_mixed_traffic(int count);
		int stop_at;
		int n;
		int j;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				run_pulse_train($urandom_range(6, 1));
			end else begin
				n = $urandom_range(3, 1);
				for (j = 0; j < n; j++)
					send_sample(pbrd_pkg::SAMPLE_W'($urandom), pbrd_pkg::TIME_W'($urandom));
			end
		end
	endtask

	// Picks a register setting: a normal heart-rate window most of the time,
	// sometimes a window of a few milliseconds that pushes the rate far above
	// the valid band, sometimes a very wide one that drives it toward zero.
	task automatic pick_random_config();
		int thr;
		int pick;
		thr  = $urandom_range(3600, 400);
		pick = $urandom_range(99);
		if (pick < 60)
			load_config(pbrd_pkg::THR_W'(thr), pbrd_pkg::HYST_W'($urandom_range(300, 0)),
				pbrd_pkg::IVL_W'($urandom_range(400, 250)),
				pbrd_pkg::IVL_W'($urandom_range(1800, 1000)));
		else if (pick < 80)
			load_config(pbrd_pkg::THR_W'(thr), pbrd_pkg::HYST_W'($urandom_range(50, 0)),
				pbrd_pkg::IVL_W'($urandom_range(2, 1)),
				pbrd_pkg::IVL_W'($urandom_range(40, 3)));
		else
			load_config(pbrd_pkg::THR_W'(thr), pbrd_pkg::HYST_W'($urandom_range(300, 0)),
				pbrd_pkg::IVL_W'($urandom_range(3000, 1000)),
				pbrd_pkg::IVL_W'($urandom_range(65535, 20000)));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Comparator edges, the interval window bounds, a beat at time zero, the
	// 32-bit timestamp wrap and ring saturation, all at the reset settings.
	task automatic test_directed_edges();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_sample(12'd0, 32'd0);
		// A beat stamped at zero leaves the next beat with nothing to measure.
		send_sample(12'd4095, 32'd0);
		send_sample(12'd1947, 32'd10);     // just below the falling level
		send_sample(12'd4095, 32'd600);    // beat that only records its time
		send_sample(12'd1948, 32'd610);    // at the falling level, stays high
		send_sample(12'd2149, 32'd700);    // already high, no new beat
		send_sample(12'd0, 32'd720);
		send_sample(12'd2148, 32'd900);    // at the rising level, no beat
		send_sample(12'd2149, 32'd933);    // interval exactly at the minimum
		send_sample(12'd0, 32'd940);
		send_sample(12'd4095, 32'd2433);   // exactly at the maximum, first rate
		send_sample(12'd0, 32'd2440);
		send_sample(12'd4095, 32'd2765);   // one below the minimum, rejected
		send_sample(12'd0, 32'd2770);
		send_sample(12'd4095, 32'd4266);   // one above the maximum, rejected
		send_sample(12'd0, 32'd4270);
		send_sample(12'd4095, 32'hFFFF_FF00);
		send_sample(12'd0, 32'hFFFF_FF10);
		send_sample(12'd4095, 32'h0000_0200); // interval across the wrap
		send_sample(12'd0, 32'h0000_0210);
		send_sample(12'd4095, 32'h0000_0390); // ring now full
		send_sample(12'd0, 32'h0000_03A0);
		send_sample(12'd4095, 32'h0000_0520); // count saturates, slot wraps
		send_sample(12'd0, 32'h0000_0530);
		drain_results();
	endtask

	// Register extremes: threshold at both ends, zero and full hysteresis,
	// hysteresis above threshold, a window of one millisecond, and a minimum
	// above the maximum.
	task automatic test_config_extremes();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		load_config(12'd0, 11'd0, 16'd1, 16'hFFFF);
		run_mixed_traffic(25);
		drain_results();
		load_config(12'd4095, 11'd0, 16'd1, 16'hFFFF);
		run_mixed_traffic(25);
		drain_results();
		load_config(12'd1500, 11'd2047, 16'd1, 16'hFFFF);
		run_mixed_traffic(25);
		drain_results();
		load_config(12'd2048, 11'd0, 16'hFFFF, 16'd1);
		run_mixed_traffic(25);
		drain_results();
		load_config(12'd2048, 11'd0, 16'd1, 16'd1);
		run_mixed_traffic(25);
		drain_results();
		load_config(12'd2047, 11'd2047, 16'hFFFF, 16'hFFFF);
		run_mixed_traffic(15);
		drain_results();
	endtask

	// Random traffic in four idling mixes; the settings change several times
	// in each, always with the block drained first.
	task automatic test_random_traffic();
		int idle_mix[4]  = '{0, 71, 0, 36};
		int stall_mix[4] = '{0, 0, 71, 36};
		int phase;
		int seg;
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct  = idle_mix[phase];
			recv_stall_pct = stall_mix[phase];
			for (seg = 0; seg < 4; seg++) begin
				pick_random_config();
				run_mixed_traffic(90);
				drain_results();
			end
		end
	endtask

	// The receiver holds ready low for a long stretch while the sender keeps
	// offering, so the block fills and stops taking samples. Afterwards the
	// sender pauses until everything owed has arrived, then sends again.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_config(pbrd_pkg::THR_RESET, pbrd_pkg::HYST_RESET, pbrd_pkg::MIN_RESET,
			pbrd_pkg::MAX_RESET);
		hold_off_len = 400;
		hold_off_req = ~hold_off_req;
		run_mixed_traffic(20);
		drain_results();
		run_mixed_traffic(10);
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		int wait_cycles;
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = pbrd_pkg::REG_BEAT_THRESHOLD;
		cfg_data          = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.sample  = '0;
		sample_ch.time_ms = '0;
		result_ch.ready   = 1'b0;
		train_time        = pbrd_pkg::TIME_W'($urandom);
		clear_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();

		// Everything has been sent; wait out whatever is still owed and a few
		// more cycles for any stray result.
		sample_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (pending_reports.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_reports.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d results never arrived", $realtime, pending_reports.size());
		end

		if (mismatch_count == 0) begin
			$display("tb_pulse_beat_rate_detector_unit: PASS");
		end else begin
			$display("tb_pulse_beat_rate_detector_unit: FAIL");
		end
		$finish;
	end

endmodule

/* pulse_beat_rate_detector_unit.f */
rtl/core/pbrd_pkg.sv
rtl/core/pbrd_sample_if.sv
rtl/core/pbrd_result_if.sv
rtl/core/pbrd_div.sv
rtl/core/pulse_beat_rate_detector_unit.sv
tb/sv/tb_pulse_beat_rate_detector_unit.sv
